/* src/usb_standard_request_handler_macros.svh */
// Assertion macros shared by the standard request handler modules.
// Depends on nothing; each module that checks itself includes this file.
`ifndef USB_STANDARD_REQUEST_HANDLER_MACROS_SVH
`define USB_STANDARD_REQUEST_HANDLER_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define USBSRH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disables the check.
`define USBSRH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/usbsrh_pkg.sv */
// Types, codes and constants of the standard request handler.
// Used by every module of the block; depends on nothing.
package usbsrh_pkg;

    localparam int EP_COUNT = 16;
    localparam int MASK_W   = 32;

    localparam logic [MASK_W-1:0] EP0_BOTH =
        MASK_W'(1) | (MASK_W'(1) << EP_COUNT);
    localparam logic [MASK_W-1:0] EP_VALID =
        MASK_W'((64'(1) << (2 * EP_COUNT)) - 64'(1));

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_GET_STATUS    = 3'd0,
        OP_CLEAR_FEATURE = 3'd1,
        OP_SET_FEATURE   = 3'd2,
        OP_SET_ADDRESS   = 3'd3,
        OP_GET_CONFIG    = 3'd4,
        OP_SET_CONFIG    = 3'd5,
        OP_GET_INTERFACE = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        RCP_DEVICE    = 2'd0,
        RCP_INTERFACE = 2'd1,
        RCP_ENDPOINT  = 2'd2,
        RCP_OTHER     = 2'd3
    } rcp_t;

    typedef enum logic [2:0] {
        CFG_CONFIG_VALUE    = 3'd0,
        CFG_INTERFACE_COUNT = 3'd1,
        CFG_ENDPOINT_MASK   = 3'd2,
        CFG_SELF_POWERED    = 3'd3,
        CFG_LOCKED_MASK     = 3'd4
    } cfg_idx_t;

    localparam logic [15:0] FEAT_ENDPOINT_HALT  = 16'd0;
    localparam logic [15:0] FEAT_REMOTE_WAKEUP  = 16'd1;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  recipient;
        logic [15:0] request_value;
        logic [15:0] request_index;
    } req_t;

    typedef struct packed {
        logic              request_ok;
        logic              has_reply;
        logic [15:0]       reply_word;
        logic [6:0]        device_address;
        logic              address_pending;
        logic [MASK_W-1:0] halted_mask;
        logic [MASK_W-1:0] enabled_mask;
    } rsp_t;

    typedef struct packed {
        logic [7:0]        config_value;
        logic [5:0]        interface_count;
        logic [MASK_W-1:0] endpoint_mask;
        logic              self_powered;
        logic [MASK_W-1:0] locked_mask;
    } cfg_t;

    // A request after decoding, as it waits in the queue.
    typedef struct packed {
        op_t               op;
        rcp_t              rcp;
        logic [MASK_W-1:0] ep_bit;
        logic              ep_zero;
        logic              feat_halt;
        logic              feat_wakeup;
        logic [7:0]        value_byte;
        logic [7:0]        index_byte;
    } cls_t;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic avail;
    } q_stat_t;

endpackage

/* src/usbsrh_front.sv */
// Front end: accepts requests and decodes them into queue entries.
// Depends on usbsrh_pkg.
module usbsrh_front (
    input  logic                  req_valid,
    output logic                  req_stall,
    input  usbsrh_pkg::req_t      req_data,
    input  usbsrh_pkg::q_stat_t   q_stat,
    output logic                  push,
    output usbsrh_pkg::cls_t      item
);
    import usbsrh_pkg::*;

    logic [3:0] ep_num;
    logic       ep_exists;
    logic [4:0] ep_shift;

    assign req_stall = q_stat.full;
    assign push      = req_valid && !q_stat.full;

    assign ep_num    = req_data.request_index[3:0];
    assign ep_exists = ({28'd0, ep_num} < 32'(EP_COUNT));
    // IN endpoints sit in the upper half of the masks.
    assign ep_shift  = req_data.request_index[7] ? (5'(EP_COUNT) + {1'b0, ep_num})
                                                 : {1'b0, ep_num};

    always_comb
    begin
        item.op          = op_t'(req_data.operation);
        item.rcp         = rcp_t'(req_data.recipient);
        item.ep_bit      = ep_exists ? (MASK_W'(1) << ep_shift) : '0;
        item.ep_zero     = (ep_num == 4'd0);
        item.feat_halt   = (req_data.request_value == FEAT_ENDPOINT_HALT);
        item.feat_wakeup = (req_data.request_value == FEAT_REMOTE_WAKEUP);
        item.value_byte  = req_data.request_value[7:0];
        item.index_byte  = req_data.request_index[7:0];
    end

endmodule

/* src/usbsrh_queue.sv */
// Short queue between the decoder and the executing back end.
// Depends on usbsrh_pkg and the assertion macro header.
`include "usb_standard_request_handler_macros.svh"

module usbsrh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  usbsrh_pkg::cls_t    push_item,
    input  logic                pop,
    output usbsrh_pkg::cls_t    head,
    output usbsrh_pkg::q_stat_t stat
);
    import usbsrh_pkg::*;

    cls_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        logic [Q_PTR_W-1:0] r;
        if (p == Q_PTR_W'(Q_DEPTH - 1))
            r = '0;
        else
            r = p + Q_PTR_W'(1);
        return r;
    endfunction

    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.avail = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    `USBSRH_ASSERT_NOW(a_pop_not_empty, clk, rst_n, pop, count_reg != '0, "pop from empty queue")
    `USBSRH_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == Q_CNT_W'($past(count_reg) + 1), "queue count did not rise")
    `USBSRH_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_reg == Q_CNT_W'($past(count_reg) - 1), "queue count did not fall")

endmodule

/* src/usbsrh_back.sv */
// Back end: executes decoded requests against the device state and
// holds the response register. Depends on usbsrh_pkg and the macro header.
`include "usb_standard_request_handler_macros.svh"

module usbsrh_back (
    input  logic                clk,
    input  logic                rst_n,
    input  usbsrh_pkg::cfg_t    cfg,
    input  usbsrh_pkg::q_stat_t q_stat,
    input  usbsrh_pkg::cls_t    head,
    output logic                pop,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output usbsrh_pkg::rsp_t    rsp_data
);
    import usbsrh_pkg::*;

    logic [7:0]        cur_config_reg, cur_config_next;
    logic [6:0]        address_reg, address_next;
    logic              wakeup_reg, wakeup_next;
    logic              self_pwr_reg, self_pwr_next;
    logic [MASK_W-1:0] enabled_reg, enabled_next;
    logic [MASK_W-1:0] halted_reg, halted_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic        ok, has, addr_set, ep_enabled, configured, if_exists;
    logic [15:0] reply;

    assign pop        = q_stat.avail && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_reg;

    assign ep_enabled = ((head.ep_bit & enabled_reg) != '0);
    assign configured = (cur_config_reg != 8'd0);
    assign if_exists  = (head.index_byte < {2'b00, cfg.interface_count});

    always_comb
    begin
        cur_config_next = cur_config_reg;
        address_next    = address_reg;
        wakeup_next     = wakeup_reg;
        self_pwr_next   = self_pwr_reg;
        enabled_next    = enabled_reg;
        halted_next     = halted_reg;
        ok              = 1'b0;
        has             = 1'b0;
        reply           = 16'd0;
        addr_set        = 1'b0;

        case (head.op)
            OP_GET_STATUS:
            begin
                case (head.rcp)
                    RCP_DEVICE:
                    begin
                        ok    = 1'b1;
                        has   = 1'b1;
                        reply = {14'd0, wakeup_reg, self_pwr_reg};
                    end
                    RCP_INTERFACE:
                    begin
                        ok  = configured && if_exists;
                        has = ok;
                    end
                    RCP_ENDPOINT:
                    begin
                        // Before configuration only endpoint zero answers.
                        ok    = ep_enabled && (configured || head.ep_zero);
                        has   = ok;
                        reply = {15'd0, ok && ((head.ep_bit & halted_reg) != '0)};
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_CLEAR_FEATURE, OP_SET_FEATURE:
            begin
                if (head.rcp == RCP_DEVICE)
                begin
                    if (head.feat_wakeup)
                    begin
                        wakeup_next = (head.op == OP_SET_FEATURE);
                        ok          = 1'b1;
                    end
                end
                else if (head.rcp == RCP_ENDPOINT)
                begin
                    if (ep_enabled && configured && !head.ep_zero && head.feat_halt)
                    begin
                        ok = 1'b1;
                        if (head.op == OP_SET_FEATURE)
                            halted_next = halted_reg | head.ep_bit;
                        else if ((cfg.locked_mask & head.ep_bit) == '0)
                            halted_next = halted_reg & ~head.ep_bit;
                    end
                end
            end
            OP_SET_ADDRESS:
            begin
                if (head.rcp == RCP_DEVICE)
                begin
                    address_next = head.value_byte[6:0];
                    addr_set     = 1'b1;
                    ok           = 1'b1;
                end
            end
            OP_GET_CONFIG:
            begin
                if (head.rcp == RCP_DEVICE)
                begin
                    ok    = 1'b1;
                    has   = 1'b1;
                    reply = {8'd0, cur_config_reg};
                end
            end
            OP_SET_CONFIG:
            begin
                if (head.rcp == RCP_DEVICE)
                begin
                    if (head.value_byte == 8'd0)
                    begin
                        cur_config_next = 8'd0;
                        enabled_next    = EP0_BOTH;
                        halted_next     = '0;
                    end
                    else if (head.value_byte == cfg.config_value)
                    begin
                        cur_config_next = head.value_byte;
                        enabled_next    = EP0_BOTH | (cfg.endpoint_mask & EP_VALID);
                        halted_next     = '0;
                        self_pwr_next   = cfg.self_powered;
                    end
                    // An unknown value is still accepted when it is already current.
                    ok = (cur_config_next == head.value_byte);
                end
            end
            OP_GET_INTERFACE:
            begin
                ok  = (head.rcp == RCP_INTERFACE) && configured && if_exists;
                has = ok;
            end
            default:
            begin
            end
        endcase

        rsp_next.request_ok      = ok;
        rsp_next.has_reply       = has;
        rsp_next.reply_word      = reply;
        rsp_next.device_address  = address_next;
        rsp_next.address_pending = addr_set;
        rsp_next.halted_mask     = halted_next;
        rsp_next.enabled_mask    = enabled_next;

        if (pop)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_config_reg <= 8'd0;
            address_reg    <= 7'd0;
            wakeup_reg     <= 1'b0;
            self_pwr_reg   <= 1'b0;
            enabled_reg    <= EP0_BOTH;
            halted_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (pop)
            begin
                cur_config_reg <= cur_config_next;
                address_reg    <= address_next;
                wakeup_reg     <= wakeup_next;
                self_pwr_reg   <= self_pwr_next;
                enabled_reg    <= enabled_next;
                halted_reg     <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rsp_reg <= rsp_next;
    end

    `USBSRH_ASSERT_NOW(a_reply_only_ok, clk, rst_n, rsp_valid_reg && rsp_reg.has_reply, rsp_reg.request_ok, "reply word on a stalled request")
    `USBSRH_ASSERT_NOW(a_halt_subset, clk, rst_n, 1'b1, (halted_reg & ~enabled_reg) == '0, "halt bit set on a disabled endpoint")

endmodule

/* src/usb_standard_request_handler.sv */
// USB standard request handler: takes one decoded setup request per cycle while req_stall is low.
// Requests arrive on req_valid/req_stall/req_data; a request is taken at a
// clock edge with req_valid high and req_stall low.
// Responses leave on rsp_valid/rsp_stall/rsp_data, one per request, in order.
// A response carries ok or stall, an optional reply word, and the device
// address, address-pending flag and endpoint halt and enable masks after it.
// The configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; the user must write it only while no request is in flight, and the
// block itself does not enforce this. A request is registered in the queue
// and then in the back end's response register before its response is valid.
// Throughput is one request per cycle while rsp_stall does not hold; the back
// end updates its state as it pops each request. A two-entry queue lets the
// decoder keep accepting while the response register waits; when rsp_stall
// holds, the queue fills and req_stall rises.
// Reset returns the device to unconfigured, address zero, only endpoint
// zero enabled and no halts, and the configuration registers to defaults.
// Depends on usbsrh_pkg and the modules usbsrh_front, usbsrh_queue, usbsrh_back.
module usb_standard_request_handler (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  usbsrh_pkg::req_t req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output usbsrh_pkg::rsp_t rsp_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import usbsrh_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    q_stat_t q_stat;
    cls_t    front_item, q_head;
    logic    push, pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CONFIG_VALUE:    cfg_next.config_value    = cfg_data[7:0];
                CFG_INTERFACE_COUNT: cfg_next.interface_count = cfg_data[5:0];
                CFG_ENDPOINT_MASK:   cfg_next.endpoint_mask   = cfg_data;
                CFG_SELF_POWERED:    cfg_next.self_powered    = cfg_data[0];
                CFG_LOCKED_MASK:     cfg_next.locked_mask     = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.config_value    <= 8'd1;
            cfg_reg.interface_count <= 6'd1;
            cfg_reg.endpoint_mask   <= 32'h0001_0001;
            cfg_reg.self_powered    <= 1'b0;
            cfg_reg.locked_mask     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    usbsrh_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .q_stat    (q_stat),
        .push      (push),
        .item      (front_item)
    );

    usbsrh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    usbsrh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .head      (q_head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
